### rtl/core/iss_pkg.sv
// shared types and constants for the insertion sorter with shift counts
// no dependencies; used by iss_cell and insertion_sorter_with_shift_counts
`default_nettype none

package iss_pkg;

	// field widths of the words
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 6;
	localparam int TOTAL_W = 11;

	// result word kinds
	localparam logic KIND_REPORT  = 1'b0;
	localparam logic KIND_ELEMENT = 1'b1;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic                    insert;
		logic                    shift;
		logic signed [VAL_W-1:0] value;
	} iss_cmd_t;

endpackage

`default_nettype wire

### rtl/core/iss_cell.sv
// one compare-and-shift cell of the sorting chain
// depends on iss_pkg for the command struct and value width
`default_nettype none

module iss_cell (
	input  wire logic                              clk,
	input  wire iss_pkg::iss_cmd_t                 cmd,
	input  wire logic                              occupied,
	input  wire logic                              is_slot,
	input  wire logic signed [iss_pkg::VAL_W-1:0]  prev_val,
	input  wire logic                              prev_gt,
	input  wire logic signed [iss_pkg::VAL_W-1:0]  next_val,
	output logic signed [iss_pkg::VAL_W-1:0]       val,
	output logic                                   gt
);

	logic signed [iss_pkg::VAL_W-1:0] val_q;

	// stored value moves up when it is greater than the incoming one
	assign gt  = occupied && (val_q > cmd.value);
	assign val = val_q;

	// insert takes the left neighbor or the new word, drain takes the right neighbor
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			val_q <= next_val;
		end else if (cmd.insert && (gt || is_slot)) begin
			val_q <= prev_gt ? prev_val : cmd.value;
		end
	end

endmodule

`default_nettype wire

### rtl/core/insertion_sorter_with_shift_counts.sv
// A word accepted into a non-empty, non-full chain registers its insertion report.
// Throughput is one input word per cycle while last is low and out_stall is low.
// A last word starts a drain of one sorted word per cycle while out_stall is low,
// one per stored value, as the chain shifts toward cell zero; no input is taken then.
// Reset clears the control and counters; cell contents stay undefined, no clearing pass.
// top level: sorter control, output register and the row of iss_cell cells
// depends on iss_pkg and iss_cell
`default_nettype none

module insertion_sorter_with_shift_counts #(
	parameter int MAX_LEN = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [iss_pkg::VAL_W-1:0]    value,
	input  wire logic                                last,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     kind,
	output logic signed [iss_pkg::VAL_W-1:0]         sorted_value,
	output logic [iss_pkg::CNT_W-1:0]                shifts,
	output logic [iss_pkg::CNT_W-1:0]                outer_count,
	output logic [iss_pkg::TOTAL_W-1:0]              total_shifts,
	output logic                                     overflow,
	output logic                                     end_of_run
);

	localparam int CW = iss_pkg::CNT_W;
	localparam int TW = iss_pkg::TOTAL_W;
	localparam int VW = iss_pkg::VAL_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);

	typedef enum logic {ST_IDLE, ST_DRAIN} state_t;

	state_t                state_q;
	logic [CW-1:0]         fill_q;
	logic [CW-1:0]         insert_q;
	logic [TW-1:0]         total_q;
	logic                  dropped_q;

	logic                  out_valid_q;
	logic                  kind_q;
	logic signed [VW-1:0]  sorted_q;
	logic [CW-1:0]         shifts_q;
	logic [CW-1:0]         outer_q;
	logic [TW-1:0]         total_out_q;
	logic                  overflow_q;
	logic                  eor_q;

	iss_pkg::iss_cmd_t     cmd;
	logic                  out_free;
	logic                  accept;
	logic                  full;
	logic                  do_report;
	logic                  drain_step;

	logic signed [VW-1:0]  cell_val [MAX_LEN];
	logic [MAX_LEN-1:0]    gt_vec;
	logic [MAX_LEN-1:0]    gt_prev;
	logic [MAX_LEN-1:0]    rise;
	logic [CW-1:0]         pos;
	logic [CW-1:0]         moved;
	logic [CW-1:0]         insert_next;
	logic [TW-1:0]         total_next;

	// handshake
	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != ST_IDLE) || !out_free;
	assign accept     = in_valid && !in_stall;
	assign full       = (fill_q == MAX_CNT);
	assign do_report  = accept && !full && (fill_q != '0);
	assign drain_step = (state_q == ST_DRAIN) && out_free;

	// command to the chain
	assign cmd = '{insert: accept && !full, shift: drain_step, value: value};

	// row of cells
	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		logic signed [VW-1:0] prev_v;
		logic signed [VW-1:0] next_v;
		logic                 prev_g;
		if (i == 0) begin : g_first
			assign prev_v = value;
			assign prev_g = 1'b0;
		end else begin : g_mid
			assign prev_v = cell_val[i-1];
			assign prev_g = gt_vec[i-1];
		end
		if (i == MAX_LEN - 1) begin : g_last
			assign next_v = cell_val[i];
		end else begin : g_inner
			assign next_v = cell_val[i+1];
		end
		iss_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.occupied (CW'(i) < fill_q),
			.is_slot  (CW'(i) == fill_q),
			.prev_val (prev_v),
			.prev_gt  (prev_g),
			.next_val (next_v),
			.val      (cell_val[i]),
			.gt       (gt_vec[i])
		);
	end

	// shift count from the thermometer of greater flags
	assign gt_prev = {gt_vec[MAX_LEN-2:0], 1'b0};
	assign rise    = gt_vec & ~gt_prev;

	always_comb begin
		pos = '0;
		for (int i = 0; i < MAX_LEN; i++) begin
			pos = pos | (rise[i] ? CW'(i) : '0);
		end
	end

	assign moved       = (|gt_vec) ? (fill_q - pos) : '0;
	assign insert_next = insert_q + CW'(1);
	assign total_next  = total_q + TW'(moved);

	// control state, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			insert_q    <= '0;
			total_q     <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// output word valid: set on a new word, cleared once taken
			if (do_report || drain_step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							fill_q <= fill_q + CW'(1);
						end
						if (do_report) begin
							insert_q    <= insert_next;
							total_q     <= total_next;
							kind_q      <= iss_pkg::KIND_REPORT;
							sorted_q    <= '0;
							shifts_q    <= moved;
							outer_q     <= insert_next;
							total_out_q <= total_next;
							overflow_q  <= dropped_q;
							eor_q       <= 1'b0;
						end
						if (last) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (drain_step) begin
						kind_q      <= iss_pkg::KIND_ELEMENT;
						sorted_q    <= cell_val[0];
						shifts_q    <= '0;
						outer_q     <= insert_q;
						total_out_q <= total_q;
						overflow_q  <= dropped_q;
						eor_q       <= (fill_q == CW'(1));
						fill_q      <= fill_q - CW'(1);
						if (fill_q == CW'(1)) begin
							state_q   <= ST_IDLE;
							insert_q  <= '0;
							total_q   <= '0;
							dropped_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign sorted_value = sorted_q;
	assign shifts       = shifts_q;
	assign outer_count  = outer_q;
	assign total_shifts = total_out_q;
	assign overflow     = overflow_q;
	assign end_of_run   = eor_q;

`ifndef ASSERT_OFF
	// fill count never passes the chain length
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= MAX_CNT)
		else $error("fill count beyond chain length");

	// a drain never runs on an empty chain
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (fill_q != '0))
		else $error("drain with empty chain");

	// once the final word is shown the sorter is idle and empty
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && eor_q) |-> (state_q == ST_IDLE && fill_q == '0 && insert_q == '0))
		else $error("end of run without cleared state");

	// report words carry no element and element words carry no shift count
	a_kind_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((kind_q == iss_pkg::KIND_REPORT) ? (sorted_q == '0)
			: (shifts_q == '0)))
		else $error("field not zero for word kind");
`endif

endmodule

`default_nettype wire

### verif/tb_insertion_sorter_with_shift_counts.sv
// self-checking testbench for insertion_sorter_with_shift_counts: directed and random runs
// with random idling on both sides; an in-bench sorter predicts every output word
// depends on iss_pkg and the insertion_sorter_with_shift_counts rtl
`default_nettype none

module tb_insertion_sorter_with_shift_counts;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VAL_W   = iss_pkg::VAL_W;
	localparam int CNT_W   = iss_pkg::CNT_W;
	localparam int TOTAL_W = iss_pkg::TOTAL_W;

	localparam int MAX_LEN = 32;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_SLACK = MAX_LEN + 8;
	localparam int HOLD_CYCLES = 300;
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	// one output word as the block presents it
	typedef struct packed {
		logic                    kind;
		logic signed [VAL_W-1:0] sorted_value;
		logic [CNT_W-1:0]        shifts;
		logic [CNT_W-1:0]        outer_count;
		logic [TOTAL_W-1:0]      total_shifts;
		logic                    overflow;
		logic                    end_of_run;
	} sort_word_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic signed [VAL_W-1:0] value;
	logic                    last;
	logic                    out_valid;
	logic                    out_stall;
	logic                    kind;
	logic signed [VAL_W-1:0] sorted_value;
	logic [CNT_W-1:0]        shifts;
	logic [CNT_W-1:0]        outer_count;
	logic [TOTAL_W-1:0]      total_shifts;
	logic                    overflow;
	logic                    end_of_run;

	// predicted sorter state
	logic signed [VAL_W-1:0] sorted_copy [MAX_LEN];
	int                      stored_cnt;
	logic [CNT_W-1:0]        insertions;
	logic [TOTAL_W-1:0]      moves_sum;
	logic                    dropped;

	sort_word_t due_words [$];
	int         fail_cnt;
	int         cycle_cnt;
	int         send_idle_pct;
	int         recv_idle_pct;
	int         hold_req;
	int         hold_left;

	insertion_sorter_with_shift_counts #(
		.MAX_LEN(MAX_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.sorted_value(sorted_value),
		.shifts(shifts),
		.outer_count(outer_count),
		.total_shifts(total_shifts),
		.overflow(overflow),
		.end_of_run(end_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// insert one accepted word into the predicted store and queue the words it causes
	task automatic insert_sorted(input logic signed [VAL_W-1:0] v, input logic is_last);
		int pos;
		int moved;
		sort_word_t w;
		if (stored_cnt >= MAX_LEN) begin
			dropped = 1'b1;
		end else if (stored_cnt == 0) begin
			sorted_copy[0] = v;
			stored_cnt = 1;
		end else begin
			pos = stored_cnt;
			moved = 0;
			// stable: stop behind any stored value that is not greater
			while (pos > 0 && sorted_copy[pos-1] > v) begin
				sorted_copy[pos] = sorted_copy[pos-1];
				pos--;
				moved++;
			end
			sorted_copy[pos] = v;
			stored_cnt++;
			insertions = insertions + CNT_W'(1);
			moves_sum = moves_sum + moved[TOTAL_W-1:0];
			w = '{iss_pkg::KIND_REPORT, '0, moved[CNT_W-1:0], insertions, moves_sum,
				dropped, 1'b0};
			due_words.push_back(w);
		end
		if (is_last) begin
			for (int i = 0; i < stored_cnt; i++) begin
				w = '{iss_pkg::KIND_ELEMENT, sorted_copy[i], '0, insertions, moves_sum,
					dropped, i == stored_cnt - 1};
				due_words.push_back(w);
			end
			stored_cnt = 0;
			insertions = '0;
			moves_sum = '0;
			dropped = 1'b0;
		end
	endtask

	task automatic check_field(input string fname, input logic [VAL_W-1:0] want,
		input logic [VAL_W-1:0] got);
		if (got !== want) begin
			$error("%s expected %0h actual %0h", fname, want, got);
			fail_cnt++;
		end
	endtask

	// compare output words first, then fold in the input word taken at this edge
	always @(posedge clk) begin
		sort_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_words.size() == 0) begin
					$error("output word with none expected: sorted_value %0h", sorted_value);
					fail_cnt++;
				end else begin
					want = due_words.pop_front();
					check_field("kind", VAL_W'(want.kind), VAL_W'(kind));
					check_field("sorted_value", want.sorted_value, sorted_value);
					check_field("shifts", VAL_W'(want.shifts), VAL_W'(shifts));
					check_field("outer_count", VAL_W'(want.outer_count),
						VAL_W'(outer_count));
					check_field("total_shifts", VAL_W'(want.total_shifts),
						VAL_W'(total_shifts));
					check_field("overflow", VAL_W'(want.overflow), VAL_W'(overflow));
					check_field("end_of_run", VAL_W'(want.end_of_run), VAL_W'(end_of_run));
				end
			end
			if (in_valid && !in_stall)
				insert_sorted(value, last);
		end
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// offer one word, after a random gap, and hold it until taken
	task automatic send_word(input logic signed [VAL_W-1:0] v, input logic is_last);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		value <= v;
		last <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// stop offering and let every predicted word come out
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value(input int style, input int k);
		int tmp;
		case (style)
			0: return $urandom;
			1: begin
				// narrow range, many equal values
				tmp = $urandom_range(6);
				return tmp - 3;
			end
			2: begin
				case ($urandom_range(3))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			3: return k * 5 - 40;
			default: return 1000 - k * 3;
		endcase
	endfunction

	// single word runs: no report, one sorted word with end_of_run
	task automatic test_single_word_runs();
		send_word(VAL_MIN, 1'b1);
		send_word(VAL_MAX, 1'b1);
		send_word('0, 1'b1);
		wait_drained();
	endtask

	// extremes of the value field and duplicates that must stay in order
	task automatic test_extreme_values();
		send_word('0, 1'b0);
		send_word(VAL_MAX, 1'b0);
		send_word(VAL_MIN, 1'b0);
		send_word('1, 1'b0);
		send_word(1, 1'b0);
		send_word(VAL_MAX, 1'b0);
		send_word(VAL_MIN, 1'b0);
		send_word('1, 1'b1);
		wait_drained();
	endtask

	// strictly falling values: every insertion moves the whole store
	task automatic test_descending_run();
		for (int k = 0; k < 10; k++)
			send_word(VAL_MAX - k * 1000, k == 9);
		wait_drained();
	endtask

	// random runs; a few fill the store past MAX_LEN
	task automatic test_random_runs(input int word_budget);
		int sent;
		int run_len;
		int style;
		sent = 0;
		while (sent < word_budget) begin
			if ($urandom_range(7) == 0)
				run_len = $urandom_range(MAX_LEN + 4, MAX_LEN - 2);
			else
				run_len = $urandom_range(12, 1);
			style = $urandom_range(4);
			for (int k = 0; k < run_len; k++)
				send_word(pick_value(style, k), k == run_len - 1);
			sent += run_len;
		end
		wait_drained();
	endtask

	// receiver holds off while a full run streams in; the words beyond MAX_LEN are dropped
	task automatic test_full_store_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = HOLD_CYCLES;
		for (int k = 0; k < MAX_LEN + 4; k++)
			send_word(pick_value(0, k), k == MAX_LEN + 3);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		last = 1'b0;
		out_stall = 1'b0;
		stored_cnt = 0;
		insertions = '0;
		moves_sum = '0;
		dropped = 1'b0;
		fail_cnt = 0;
		cycle_cnt = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 0;
		hold_left = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 34;
		recv_idle_pct = 86;
		test_single_word_runs();
		test_extreme_values();
		test_descending_run();
		test_random_runs(130);

		send_idle_pct = 86;
		recv_idle_pct = 34;
		test_random_runs(130);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_runs(130);

		test_full_store_backpressure();

		if (fail_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
